// File: hw/rtl/easing_curve_evaluator_unit_macros.svh
// Assertion macros for the easing curve evaluator.
// Used by the RTL files that carry checks; no other dependencies.
`ifndef EASING_CURVE_EVALUATOR_UNIT_MACROS_SVH
`define EASING_CURVE_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`ifndef SYNTH
`define ECE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ece check failed");
`else
`define ECE_ASSERT_NOW(lbl, ante, cons)
`endif

// Next-cycle implication, clocked on i_clk, off during reset.
`ifndef SYNTH
`define ECE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ece check failed");
`else
`define ECE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/ece_pkg.sv
// Shared types, constants and rounding multiply helpers for the easing evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ece_pkg;

    localparam int NST = 8;     // register stages from input to result
    localparam int WW  = 34;    // internal signed word

    typedef logic signed [WW-1:0] t_word;

    typedef struct packed {
        logic [NST-1:0] en;
        logic [NST-1:0] vld;
    } t_stage_ctl;

    typedef enum logic [3:0] {
        CRV_LINEAR      = 4'd0,
        CRV_QUAD_IN     = 4'd1,
        CRV_QUAD_OUT    = 4'd2,
        CRV_QUAD_INOUT  = 4'd3,
        CRV_CUBIC_IN    = 4'd4,
        CRV_CUBIC_OUT   = 4'd5,
        CRV_CUBIC_INOUT = 4'd6,
        CRV_ELASTIC_IN  = 4'd7,
        CRV_ELASTIC_OUT = 4'd8,
        CRV_BOUNCE_IN   = 4'd9,
        CRV_BOUNCE_OUT  = 4'd10
    } t_curve;

    localparam logic [4:0] Q30_SH = 5'd30;
    localparam t_word Q30_ONE = 34'sd1073741824;
    localparam t_word SIN_A   = 34'sd1686629713;
    localparam t_word SIN_B   = -34'sd688904837;
    localparam t_word SIN_C   = 34'sd76016948;
    localparam t_word EXP_C1  = 34'sd747324310;
    localparam t_word EXP_C2  = 34'sd241699285;
    localparam t_word EXP_C3  = 34'sd84718230;

    localparam t_word EASE_MAX = 34'sd131071;
    localparam t_word EASE_MIN = -34'sd131072;

    // ceil(2^35 / 3), split in two partial products
    localparam logic [34:0] DIV3_M  = 35'h2AAAAAAAB;
    localparam logic [17:0] DIV3_ML = DIV3_M[17:0];
    localparam logic [16:0] DIV3_MH = DIV3_M[34:18];

    // signed product >> s, rounding half away from zero
    function automatic t_word mulq(input t_word a, input t_word b, input logic [4:0] s);
        logic [WW-1:0]   ma;
        logic [WW-1:0]   mb;
        logic [2*WW-1:0] p;
        logic            neg;
        ma  = a[WW-1] ? $unsigned(-a) : $unsigned(a);
        mb  = b[WW-1] ? $unsigned(-b) : $unsigned(b);
        neg = a[WW-1] ^ b[WW-1];
        p   = {{WW{1'b0}}, ma} * {{WW{1'b0}}, mb};
        p   = (p + ((2*WW)'(1) << (s - 5'd1))) >> s;
        mulq = neg ? -t_word'(p[WW-1:0]) : t_word'(p[WW-1:0]);
    endfunction

    // signed shift right, rounding half away from zero
    function automatic t_word rshr(input t_word v, input logic [4:0] s);
        logic [WW-1:0] m;
        m = v[WW-1] ? $unsigned(-v) : $unsigned(v);
        m = (m + (WW'(1) << (s - 5'd1))) >> s;
        rshr = v[WW-1] ? -t_word'(m) : t_word'(m);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ece_pipe_ctl.sv
// Valid bits and per-stage advance enables for the evaluator pipeline.
// Depends on ece_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "easing_curve_evaluator_unit_macros.svh"

module ece_pipe_ctl
    import ece_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_stall,
    output t_stage_ctl o_ctl
);

    logic [NST-1:0]           r_vld;
    logic [NST-1:0]           n_en;
    logic                     in_acc;
    logic                     out_acc;
    logic [$clog2(NST+1)-1:0] vld_cnt;

    // a stage moves when it is empty or the one after it moves: bubbles close up
    always_comb begin
        n_en[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ctl.en  = n_en;
    assign o_ctl.vld = r_vld;
    assign in_acc    = i_valid && n_en[0];
    assign out_acc   = r_vld[NST-1] && !i_stall;
    assign vld_cnt   = $bits(vld_cnt)'($countones(r_vld));

    `ECE_ASSERT_NOW(a_empty_tail_all_move, !r_vld[NST-1], &n_en)
    `ECE_ASSERT_NEXT(a_beat_enters, in_acc, r_vld[0])
    `ECE_ASSERT_NEXT(a_beats_conserved, 1'b1, vld_cnt == $past(vld_cnt) + $past(in_acc) - $past(out_acc))

endmodule

`default_nettype wire

// File: hw/rtl/easing_curve_evaluator_unit.sv
// Easing curve evaluator top level: clamp, polynomial, bounce and elastic lanes.
// Depends on ece_pkg and ece_pipe_ctl.
//
//   channel  dir  handshake          payload
//   input    in   i_valid / o_stall  i_func[3:0], i_progress[17:0] signed
//   output   out  o_valid / i_stall  o_eased[17:0] signed
//
// One beat per cycle sustained while i_stall is low; pipeline depth is set by the elastic lane:
// divide-by-3 phase, four chained sine multiplies and the final product.
// Reset clears only the stage valid bits.
// A stalled output holds its beat; empty stages still fill, so input is taken
// until every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module easing_curve_evaluator_unit
    import ece_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_func,
    input  wire logic signed [17:0] i_progress,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [17:0]      o_eased
);

    localparam t_word ONE = t_word'(64'sd1 <<< FRAC_BITS);
    localparam logic [4:0] SH_F  = 5'(FRAC_BITS);
    localparam logic [4:0] SH_F4 = 5'(FRAC_BITS + 4);
    localparam logic [4:0] SH_F6 = 5'(FRAC_BITS + 6);
    localparam logic [4:0] SH_Q  = 5'(30 - FRAC_BITS);
    localparam t_word K4   = ONE * 4;
    localparam t_word K6   = ONE * 6;
    localparam t_word K8   = ONE * 8;
    localparam t_word K9   = ONE * 9;
    localparam t_word K10  = ONE * 10;
    localparam t_word K21  = ONE * 21;
    localparam t_word OFF1 = (ONE * 3) / 4;
    localparam t_word OFF2 = (ONE * 15) / 16;
    localparam t_word OFF3 = (ONE * 63) / 64;

    t_stage_ctl ctl;

    ece_pipe_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    assign o_stall = !ctl.en[0];
    assign o_valid = ctl.vld[NST-1];

    // the last stage only needs the result, so these stop one short
    t_curve r_func [NST-1];
    t_word  r_t    [NST-1];

    // ---------------- stage 0: clamp, elastic phase and exponent numerators
    t_word       n_prog;
    t_word       n_t;
    logic [34:0] n_t30;
    logic [34:0] n_ten;
    logic [34:0] n_v;
    logic [34:0] n_e;
    logic [34:0] r_v0;
    logic [34:0] r_e0;

    always_comb begin
        n_prog = t_word'(i_progress);
        if (n_prog < 0) begin
            n_t = '0;
        end else if (n_prog > ONE) begin
            n_t = ONE;
        end else begin
            n_t = n_prog;
        end
        n_t30 = 35'(n_t) << SH_Q;
        n_ten = (n_t30 << 3) + (n_t30 << 1);
        if (t_curve'(i_func) == CRV_ELASTIC_OUT) begin
            n_v = n_ten + (35'd9 << 28);
            n_e = (35'd10 << 30) - n_ten;
        end else begin
            n_v = n_ten + (35'd5 << 28);
            n_e = n_ten;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_func[0] <= t_curve'(i_func);
            r_t[0]    <= n_t;
            r_v0      <= n_v;
            r_e0      <= n_e;
        end
    end

    for (genvar k = 1; k < NST - 1; k++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (ctl.en[k]) begin
                r_func[k] <= r_func[k-1];
                r_t[k]    <= r_t[k-1];
            end
        end
    end

    // ---------------- stage 1: square, bounce piece, divide partials, exp step 1
    t_word       n_u1;
    logic        n_lower1;
    t_word       n_a1;
    t_word       n_bx;
    t_word       n_b11;
    t_word       n_bd;
    logic        n_blast;
    t_word       n_boff;
    t_word       n_f1w;
    t_word       r_a1;
    t_word       r_m2_1;
    logic        r_lower1;
    t_word       r_bd1;
    logic        r_blast1;
    t_word       r_boff1;
    logic [51:0] r_ph1;
    logic [52:0] r_pl1;
    t_word       r_pw1;
    logic [29:0] r_f1;
    logic [3:0]  r_n1;

    always_comb begin
        n_u1     = ONE - r_t[0];
        n_lower1 = (r_t[0] <<< 1) < ONE;
        if (r_func[0] inside {CRV_QUAD_IN, CRV_CUBIC_IN}) begin
            n_a1 = r_t[0];
        end else if (r_func[0] inside {CRV_QUAD_OUT, CRV_CUBIC_OUT}) begin
            n_a1 = n_u1;
        end else begin
            n_a1 = n_lower1 ? r_t[0] : n_u1;
        end
        n_bx    = (r_func[0] == CRV_BOUNCE_IN) ? n_u1 : r_t[0];
        n_b11   = (n_bx <<< 3) + (n_bx <<< 1) + n_bx;
        n_blast = 1'b0;
        if (n_b11 < K4) begin
            n_bd   = n_b11;
            n_boff = '0;
        end else if (n_b11 < K8) begin
            n_bd   = n_b11 - K6;
            n_boff = OFF1;
        end else if (n_b11 < K10) begin
            n_bd   = n_b11 - K9;
            n_boff = OFF2;
        end else begin
            // last piece: (22t - 21) squared over 64
            n_bd    = (n_b11 <<< 1) - K21;
            n_boff  = OFF3;
            n_blast = 1'b1;
        end
        n_f1w = t_word'({4'd0, r_e0[29:0]});
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[1]) begin
            r_a1     <= n_a1;
            r_m2_1   <= mulq(n_a1, n_a1, SH_F);
            r_lower1 <= n_lower1;
            r_bd1    <= n_bd;
            r_blast1 <= n_blast;
            r_boff1  <= n_boff;
            r_ph1    <= 52'(r_v0) * 52'(DIV3_MH);
            r_pl1    <= 53'(r_v0) * 53'(DIV3_ML);
            r_pw1    <= mulq(n_f1w, EXP_C3, Q30_SH) + EXP_C2;
            r_f1     <= r_e0[29:0];
            r_n1     <= r_e0[33:30];
        end
    end

    // ---------------- stage 2: cube, bounce square, phase, exp step 2
    logic [69:0] n_q2;
    t_word       r_m2_2;
    t_word       r_m3_2;
    logic        r_lower2;
    t_word       r_bq2;
    logic [29:0] r_phase2;
    t_word       r_pw2;
    logic [29:0] r_f2;
    logic [3:0]  r_n2;

    assign n_q2 = ({18'd0, r_ph1} << 18) + {17'd0, r_pl1};

    always_ff @(posedge i_clk) begin
        if (ctl.en[2]) begin
            r_m2_2   <= r_m2_1;
            r_m3_2   <= mulq(r_m2_1, r_a1, SH_F);
            r_lower2 <= r_lower1;
            r_bq2    <= mulq(r_bd1, r_bd1, r_blast1 ? SH_F6 : SH_F4) + r_boff1;
            r_phase2 <= n_q2[64:35];
            r_pw2    <= mulq(t_word'({4'd0, r_f1}), r_pw1, Q30_SH) + EXP_C1;
            r_f2     <= r_f1;
            r_n2     <= r_n1;
        end
    end

    // ---------------- stage 3: quarter-wave fold and x^2, exp step 3, other curves
    logic [1:0] n_quad3;
    t_word      n_x3;
    t_word      n_xs3;
    t_word      n_oth3;
    t_word      r_xs3;
    t_word      r_x2_3;
    logic [1:0] r_quad3;
    t_word      r_pw3;
    logic [3:0] r_n3;
    t_word      r_oth3;

    always_comb begin
        n_quad3 = r_phase2[29:28];
        n_x3    = t_word'({4'd0, r_phase2[27:0], 2'b00});
        n_xs3   = n_quad3[0] ? Q30_ONE - n_x3 : n_x3;
        case (r_func[2])
            CRV_QUAD_IN:     n_oth3 = r_m2_2;
            CRV_QUAD_OUT:    n_oth3 = ONE - r_m2_2;
            CRV_QUAD_INOUT:  n_oth3 = r_lower2 ? (r_m2_2 <<< 1) : ONE - (r_m2_2 <<< 1);
            CRV_CUBIC_IN:    n_oth3 = r_m3_2;
            CRV_CUBIC_OUT:   n_oth3 = ONE - r_m3_2;
            CRV_CUBIC_INOUT: n_oth3 = r_lower2 ? (r_m3_2 <<< 2) : ONE - (r_m3_2 <<< 2);
            CRV_BOUNCE_IN:   n_oth3 = ONE - r_bq2;
            CRV_BOUNCE_OUT:  n_oth3 = r_bq2;
            default:         n_oth3 = r_t[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[3]) begin
            r_xs3   <= n_xs3;
            r_x2_3  <= mulq(n_xs3, n_xs3, Q30_SH);
            r_quad3 <= n_quad3;
            r_pw3   <= mulq(t_word'({4'd0, r_f2}), r_pw2, Q30_SH) + Q30_ONE;
            r_n3    <= r_n2;
            r_oth3  <= n_oth3;
        end
    end

    // ---------------- stage 4: sine step 1, power scale
    t_word      r_xs4;
    t_word      r_x2_4;
    t_word      r_ws1_4;
    logic [1:0] r_quad4;
    t_word      r_p4;
    t_word      r_oth4;

    always_ff @(posedge i_clk) begin
        if (ctl.en[4]) begin
            r_xs4   <= r_xs3;
            r_x2_4  <= r_x2_3;
            r_ws1_4 <= mulq(r_x2_3, SIN_C, Q30_SH) + SIN_B;
            r_quad4 <= r_quad3;
            r_p4    <= (r_n3 >= 4'd10) ? r_pw3 : rshr(r_pw3, 5'(4'd10 - r_n3));
            r_oth4  <= r_oth3;
        end
    end

    // ---------------- stage 5: sine step 2
    t_word      r_xs5;
    t_word      r_ws2_5;
    logic [1:0] r_quad5;
    t_word      r_p5;
    t_word      r_oth5;

    always_ff @(posedge i_clk) begin
        if (ctl.en[5]) begin
            r_xs5   <= r_xs4;
            r_ws2_5 <= mulq(r_x2_4, r_ws1_4, Q30_SH) + SIN_A;
            r_quad5 <= r_quad4;
            r_p5    <= r_p4;
            r_oth5  <= r_oth4;
        end
    end

    // ---------------- stage 6: sine value with half-wave sign
    t_word n_s6;
    t_word r_s6;
    t_word r_p6;
    t_word r_oth6;

    assign n_s6 = mulq(r_xs5, r_ws2_5, Q30_SH);

    always_ff @(posedge i_clk) begin
        if (ctl.en[6]) begin
            r_s6   <= r_quad5[1] ? -n_s6 : n_s6;
            r_p6   <= r_p5;
            r_oth6 <= r_oth5;
        end
    end

    // ---------------- stage 7: elastic product, exact ends, saturate
    t_word             n_pr7;
    t_word             n_er7;
    t_word             n_res7;
    logic signed [17:0] r_eased;

    always_comb begin
        n_pr7 = mulq(r_p6, r_s6, Q30_SH);
        if (r_func[6] == CRV_ELASTIC_OUT) begin
            n_er7 = rshr(n_pr7 + Q30_ONE, SH_Q);
        end else begin
            n_er7 = rshr(-n_pr7, SH_Q);
        end
        if (r_func[6] inside {CRV_ELASTIC_IN, CRV_ELASTIC_OUT}) begin
            if (r_t[6] == '0) begin
                n_res7 = '0;
            end else if (r_t[6] == ONE) begin
                n_res7 = ONE;
            end else begin
                n_res7 = n_er7;
            end
        end else begin
            n_res7 = r_oth6;
        end
        if (n_res7 > EASE_MAX) begin
            n_res7 = EASE_MAX;
        end else if (n_res7 < EASE_MIN) begin
            n_res7 = EASE_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[7]) begin
            r_eased <= n_res7[17:0];
        end
    end

    assign o_eased = r_eased;

endmodule

`default_nettype wire

// File: bench/tb_easing_curve_evaluator_unit.sv
// Testbench for easing_curve_evaluator_unit: directed table plus random beats,
// checked against an in-bench fixed-point predictor. Depends on ece_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tb_easing_curve_evaluator_unit
    import ece_pkg::*;
();

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam longint Q1 = 64'sd1 << 30;
    localparam int N_RAND = 1730;
    localparam int LATENCY = 8;
    localparam longint CYC_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [3:0] i_func = '0;
    logic signed [17:0] i_progress = '0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic signed [17:0] o_eased;

    easing_curve_evaluator_unit #(.FRAC_BITS(FB)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_progress(i_progress), .o_valid(o_valid),
        .i_stall(i_stall), .o_eased(o_eased)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [17:0] eased_due[$];
    int errors = 0;
    int sent = 0;
    int got = 0;
    longint cycles = 0;
    bit drive_done = 0;
    bit hold_done = 0;

    // ---------------- predictor ----------------
    function automatic longint rnd_mul(longint a, longint b, int s);
        longint ma, mb, p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb + (64'sd1 << (s - 1))) >>> s;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint rnd_shr(longint v, int s);
        longint m;
        m = ((v < 0 ? -v : v) + (64'sd1 << (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint quarter_sine(longint x);
        longint x2, w;
        x2 = rnd_mul(x, x, 30);
        w = rnd_mul(x2, 64'sd76016948, 30) - 64'sd688904837;
        w = rnd_mul(x2, w, 30) + 64'sd1686629713;
        return rnd_mul(x, w, 30);
    endfunction

    function automatic longint turn_sine(longint ph);
        int quad;
        longint x, s;
        quad = int'((ph >> 28) & 3);
        x = (ph & ((64'sd1 << 28) - 1)) << 2;
        s = (quad & 1) ? quarter_sine(Q1 - x) : quarter_sine(x);
        return (quad & 2) ? -s : s;
    endfunction

    function automatic longint exp2_m10(longint e);
        int n;
        longint f, w;
        n = int'(e >> 30);
        f = e & (Q1 - 1);
        w = rnd_mul(f, 64'sd84718230, 30) + 64'sd241699285;
        w = rnd_mul(f, w, 30) + 64'sd747324310;
        w = rnd_mul(f, w, 30) + Q1;
        if (n >= 10) return w;
        return rnd_shr(w, 10 - n);
    endfunction

    function automatic longint bounce_curve(longint t);
        longint t11, d;
        t11 = 11 * t;
        if (t11 < 4 * ONE) return rnd_mul(t11, t11, FB + 4);
        if (t11 < 8 * ONE) begin
            d = t11 - 6 * ONE;
            return rnd_mul(d, d, FB + 4) + (3 * ONE) / 4;
        end
        if (t11 < 10 * ONE) begin
            d = t11 - 9 * ONE;
            return rnd_mul(d, d, FB + 4) + (15 * ONE) / 16;
        end
        d = 22 * t - 21 * ONE;
        return rnd_mul(d, d, FB + 6) + (63 * ONE) / 64;
    endfunction

    function automatic longint elastic_curve(longint t, bit out_dir);
        longint t30, ph, p, r;
        if (t == 0) return 0;
        if (t == ONE) return ONE;
        t30 = t << (30 - FB);
        if (out_dir) begin
            ph = ((10 * t30 + (64'sd9 << 28)) / 3) & (Q1 - 1);
            p = exp2_m10((64'sd10 << 30) - 10 * t30);
            r = rnd_mul(p, turn_sine(ph), 30) + Q1;
        end else begin
            ph = ((10 * t30 + (64'sd5 << 28)) / 3) & (Q1 - 1);
            p = exp2_m10(10 * t30);
            r = -rnd_mul(p, turn_sine(ph), 30);
        end
        return rnd_shr(r, 30 - FB);
    endfunction

    function automatic logic [17:0] ease_value(logic [3:0] fn, logic signed [17:0] prog);
        longint t, u, r;
        t = prog;
        if (t < 0) t = 0;
        if (t > ONE) t = ONE;
        u = ONE - t;
        case (fn)
            CRV_QUAD_IN:     r = rnd_mul(t, t, FB);
            CRV_QUAD_OUT:    r = ONE - rnd_mul(u, u, FB);
            CRV_QUAD_INOUT:  r = (2 * t < ONE) ? 2 * rnd_mul(t, t, FB)
                                               : ONE - 2 * rnd_mul(u, u, FB);
            CRV_CUBIC_IN:    r = rnd_mul(rnd_mul(t, t, FB), t, FB);
            CRV_CUBIC_OUT:   r = ONE - rnd_mul(rnd_mul(u, u, FB), u, FB);
            CRV_CUBIC_INOUT: r = (2 * t < ONE) ? 4 * rnd_mul(rnd_mul(t, t, FB), t, FB)
                                               : ONE - 4 * rnd_mul(rnd_mul(u, u, FB), u, FB);
            CRV_ELASTIC_IN:  r = elastic_curve(t, 1'b0);
            CRV_ELASTIC_OUT: r = elastic_curve(t, 1'b1);
            CRV_BOUNCE_IN:   r = ONE - bounce_curve(u);
            CRV_BOUNCE_OUT:  r = bounce_curve(t);
            default:         r = t;
        endcase
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[17:0];
    endfunction

    // ---------------- directed table ----------------
    typedef struct {
        logic [3:0] fn;
        logic signed [17:0] prog;
        bit known;
        logic [17:0] val;
    } t_row;

    localparam int N_DIR = 24;
    t_row dir_rows[N_DIR] = '{
        '{CRV_LINEAR,      18'sh20000, 1, 18'h0},      // most negative clamps to 0
        '{CRV_LINEAR,      18'sh1FFFF, 1, 18'h10000},  // most positive clamps to one
        '{CRV_LINEAR,      -18'sd1,    1, 18'h0},
        '{CRV_LINEAR,      18'sd65537, 1, 18'h10000},
        '{CRV_QUAD_IN,     18'sd0,     1, 18'h0},
        '{CRV_QUAD_IN,     18'sd65536, 1, 18'h10000},
        '{CRV_QUAD_OUT,    18'sd20000, 0, 18'h0},
        '{CRV_QUAD_INOUT,  18'sd32767, 0, 18'h0},
        '{CRV_QUAD_INOUT,  18'sd32768, 0, 18'h0},
        '{CRV_CUBIC_IN,    18'sd65536, 1, 18'h10000},
        '{CRV_CUBIC_OUT,   18'sd1,     0, 18'h0},
        '{CRV_CUBIC_INOUT, 18'sd32768, 0, 18'h0},
        '{CRV_ELASTIC_IN,  18'sd0,     1, 18'h0},      // exact ends
        '{CRV_ELASTIC_IN,  18'sd65536, 1, 18'h10000},
        '{CRV_ELASTIC_IN,  18'sd60000, 0, 18'h0},
        '{CRV_ELASTIC_OUT, 18'sd0,     1, 18'h0},
        '{CRV_ELASTIC_OUT, 18'sd65536, 1, 18'h10000},
        '{CRV_ELASTIC_OUT, 18'sd3000,  0, 18'h0},
        '{CRV_BOUNCE_IN,   18'sd0,     1, 18'h0},
        '{CRV_BOUNCE_IN,   18'sd40000, 0, 18'h0},
        '{CRV_BOUNCE_OUT,  18'sd65536, 1, 18'h10000},
        '{CRV_BOUNCE_OUT,  18'sd61000, 0, 18'h0},
        '{4'd11,           18'sd12345, 1, 18'd12345},  // unused codes act as linear
        '{4'd15,           18'sh1FFFF, 1, 18'h10000}
    };

    // ---------------- sender ----------------
    // valid drops only when a gap follows, so back-to-back beats keep it high
    task automatic send_beat(logic [3:0] fn, logic signed [17:0] prog);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_progress <= prog;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // expectation is queued at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            eased_due.push_back(ease_value(i_func, i_progress));
            sent++;
        end
    end

    initial begin
        logic [3:0] fn;
        logic signed [17:0] prog;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < N_DIR; k++) begin
            if (dir_rows[k].known && ease_value(dir_rows[k].fn, dir_rows[k].prog)
                    != dir_rows[k].val) begin
                $display("%0t table row %0d: expected %h predicted %h", $time, k,
                         dir_rows[k].val, ease_value(dir_rows[k].fn, dir_rows[k].prog));
                errors++;
            end
            send_beat(dir_rows[k].fn, dir_rows[k].prog);
        end
        for (int k = 0; k < N_RAND; k++) begin
            fn = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 9) < 8) prog = 18'($urandom_range(0, 65536));
            else prog = 18'($urandom);
            // back-to-back burst while the receiver holds off
            if (k >= 200 && k < 260) begin
                i_valid <= 1'b1;
                i_func <= fn;
                i_progress <= prog;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
            end else begin
                send_beat(fn, prog);
            end
        end
        i_valid <= 1'b0;
        drive_done = 1;
    end

    // ---------------- receiver ----------------
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent >= 205) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                hold_done = 1;
                i_stall <= 1'b0;
            end else if (o_valid && !i_stall) begin
                hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got++;
            if (eased_due.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %h", $time, o_eased);
                errors++;
            end else begin
                if (o_eased !== eased_due[0]) begin
                    $display("%0t eased mismatch: expected %h actual %h", $time,
                             eased_due[0], o_eased);
                    errors++;
                end
                void'(eased_due.pop_front());
            end
        end
    end

    // ---------------- end of run ----------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        wait (drive_done);
        wait (eased_due.size() == 0);
        repeat (LATENCY * 4) @(posedge i_clk);
        if (eased_due.size() != 0) errors++;
        $display("Covered %0d beats in, %0d out: all curves, clamps, unused codes,", sent, got);
        $display("random gaps and a long output hold-off; %0d errors", errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
